[rtl/matrix_inverse_3x3_unit_defines.svh]
// assertion macros for the 3x3 matrix inverse unit
`ifndef MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold out of reset
`define MI3_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/mi3_pkg.sv]
// shared types and constants of the 3x3 matrix inverse unit
package mi3_pkg;

  localparam int unsigned IW      = 16;
  localparam int unsigned NENT    = 9;
  localparam int unsigned CSW     = 33;
  localparam int unsigned CMW     = 32;
  localparam int unsigned DW      = 49;
  localparam int unsigned DMW     = 48;
  localparam int unsigned QW      = 32;
  localparam int unsigned DET_LAT = 4;
  localparam int unsigned DIV_LAT = QW + 2;

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef logic [NENT-1:0][IW-1:0] mi3_mat_t;

  typedef struct packed {
    logic [NENT-1:0][CMW-1:0] cof_mag;
    logic [NENT-1:0]          cof_neg;
    logic [DMW-1:0]           det_mag;
    logic                     det_neg;
    logic                     det_zero;
  } mi3_frac_t;

endpackage

[rtl/matrix_inverse_3x3_unit.sv]
// top level of the 3x3 matrix inverse unit
//
// Inverts one 3x3 matrix of signed fixed-point entries per transaction by
// the adjugate: each output entry is cofactor * 2^(IN_FRAC_BITS+OUT_FRAC_BITS)
// divided by the determinant, truncated toward zero and saturated to 32 bits.
// A transaction is taken at a clock edge with start high and busy low;
// busy stays low, so a new matrix may enter in every cycle.
// The result shows on inv_*_o and singular_o for one cycle with done_o high,
// after four stages of cofactor and determinant logic, one stage of overflow
// check, 32 divider stages (one quotient bit each) and one saturation stage.
// Throughput is one matrix per cycle, set by the fully pipelined divider
// lanes, one per entry.
// A zero determinant gives singular_o high and all entries zero.
// Reset clears the valid pipeline; transactions in flight are dropped.
// The receiver cannot hold results off, so nothing stalls.
module matrix_inverse_3x3_unit #(
  parameter int unsigned IN_FRAC_BITS  = 12,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [mi3_pkg::IW-1:0] m_r0c0_i,
  input  logic [mi3_pkg::IW-1:0] m_r0c1_i,
  input  logic [mi3_pkg::IW-1:0] m_r0c2_i,
  input  logic [mi3_pkg::IW-1:0] m_r1c0_i,
  input  logic [mi3_pkg::IW-1:0] m_r1c1_i,
  input  logic [mi3_pkg::IW-1:0] m_r1c2_i,
  input  logic [mi3_pkg::IW-1:0] m_r2c0_i,
  input  logic [mi3_pkg::IW-1:0] m_r2c1_i,
  input  logic [mi3_pkg::IW-1:0] m_r2c2_i,
  output logic                   done_o,
  output logic [mi3_pkg::QW-1:0] inv_r0c0_o,
  output logic [mi3_pkg::QW-1:0] inv_r0c1_o,
  output logic [mi3_pkg::QW-1:0] inv_r0c2_o,
  output logic [mi3_pkg::QW-1:0] inv_r1c0_o,
  output logic [mi3_pkg::QW-1:0] inv_r1c1_o,
  output logic [mi3_pkg::QW-1:0] inv_r1c2_o,
  output logic [mi3_pkg::QW-1:0] inv_r2c0_o,
  output logic [mi3_pkg::QW-1:0] inv_r2c1_o,
  output logic [mi3_pkg::QW-1:0] inv_r2c2_o,
  output logic                   singular_o
);
  import mi3_pkg::*;

  localparam int unsigned LAT   = DET_LAT + DIV_LAT;
  localparam int unsigned SHIFT = IN_FRAC_BITS + OUT_FRAC_BITS;

  mi3_mat_t              mat;
  mi3_frac_t             frac;
  logic [NENT-1:0][QW-1:0] inv;
  logic [LAT-1:0]        vld_d, vld_q;
  logic [DIV_LAT-1:0]    sng_q;

  assign busy = 1'b0;

  assign mat = {m_r2c2_i, m_r2c1_i, m_r2c0_i, m_r1c2_i, m_r1c1_i, m_r1c0_i,
                m_r0c2_i, m_r0c1_i, m_r0c0_i};

  mi3_det u_det (
    .clk_i  (clk_i),
    .mat_i  (mat),
    .frac_o (frac)
  );

  for (genvar k = 0; k < NENT; k++) begin : g_lane
    mi3_div #(
      .SHIFT (SHIFT)
    ) u_div (
      .clk_i      (clk_i),
      .cof_mag_i  (frac.cof_mag[k]),
      .cof_neg_i  (frac.cof_neg[k]),
      .det_mag_i  (frac.det_mag),
      .det_neg_i  (frac.det_neg),
      .det_zero_i (frac.det_zero),
      .inv_o      (inv[k])
    );
  end

  assign vld_d = {vld_q[LAT-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sng_q <= {sng_q[DIV_LAT-2:0], frac.det_zero};
  end

  assign done_o     = vld_q[LAT-1];
  assign singular_o = sng_q[DIV_LAT-1];
  assign inv_r0c0_o = inv[0];
  assign inv_r0c1_o = inv[1];
  assign inv_r0c2_o = inv[2];
  assign inv_r1c0_o = inv[3];
  assign inv_r1c1_o = inv[4];
  assign inv_r1c2_o = inv[5];
  assign inv_r2c0_o = inv[6];
  assign inv_r2c1_o = inv[7];
  assign inv_r2c2_o = inv[8];

endmodule

[rtl/mi3_det.sv]
// cofactor and determinant pipeline, four register stages
module mi3_det (
  input  logic              clk_i,
  input  mi3_pkg::mi3_mat_t mat_i,
  output mi3_pkg::mi3_frac_t frac_o
);
  import mi3_pkg::*;

  localparam int unsigned PX1 [NENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PY1 [NENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned PX2 [NENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned PY2 [NENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [IW-1:0]   ent [NENT];
  logic signed [2*IW-1:0] pa_q [NENT];
  logic signed [2*IW-1:0] pb_q [NENT];
  logic signed [IW-1:0]   r0a_q [3];
  logic signed [IW-1:0]   r0b_q [3];
  logic signed [CSW-1:0]  cof_q [NENT];
  logic signed [CSW-1:0]  cofb_q [NENT];
  logic signed [DW-1:0]   dp_q [3];
  logic signed [DW-1:0]   det_s;
  mi3_frac_t              frac_d, frac_q;

  always_comb begin
    for (int k = 0; k < NENT; k++) begin
      ent[k] = $signed(mat_i[k]);
    end
  end

  // products, cofactors, determinant terms
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NENT; k++) begin
      pa_q[k]   <= ent[PX1[k]] * ent[PY1[k]];
      pb_q[k]   <= ent[PX2[k]] * ent[PY2[k]];
      cof_q[k]  <= CSW'(pa_q[k]) - CSW'(pb_q[k]);
      cofb_q[k] <= cof_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      r0a_q[k] <= ent[k];
      r0b_q[k] <= r0a_q[k];
      dp_q[k]  <= DW'(cof_q[3*k]) * DW'(r0b_q[k]);
    end
    frac_q <= frac_d;
  end

  always_comb begin
    det_s           = dp_q[0] + dp_q[1] + dp_q[2];
    frac_d.det_neg  = det_s[DW-1];
    frac_d.det_zero = (det_s == '0);
    frac_d.det_mag  = det_s[DW-1] ? DMW'(-det_s) : DMW'(det_s);
    for (int k = 0; k < NENT; k++) begin
      frac_d.cof_neg[k] = cofb_q[k][CSW-1];
      frac_d.cof_mag[k] = cofb_q[k][CSW-1] ? CMW'(-cofb_q[k]) : CMW'(cofb_q[k]);
    end
  end

  assign frac_o = frac_q;

endmodule

[rtl/mi3_div.sv]
// one inverse entry: pipelined restoring divider, one quotient bit per stage
module mi3_div #(
  parameter int unsigned SHIFT = 28
) (
  input  logic                    clk_i,
  input  logic [mi3_pkg::CMW-1:0] cof_mag_i,
  input  logic                    cof_neg_i,
  input  logic [mi3_pkg::DMW-1:0] det_mag_i,
  input  logic                    det_neg_i,
  input  logic                    det_zero_i,
  output logic [mi3_pkg::QW-1:0]  inv_o
);
  import mi3_pkg::*;

  localparam int unsigned NW = CMW + SHIFT;
  localparam int unsigned CW = ((NW > DMW + QW) ? NW : DMW + QW) + 1;

  logic [CW-1:0]  rem_q [QW+1];
  logic [CW-1:0]  rem_d [QW+1];
  logic [DMW-1:0] den_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic [QW-1:0]  quo_d [QW+1];
  logic [QW:0]    ovf_q, neg_q, zero_q;
  logic           ovf_d;
  logic [CW:0]    sub [QW];
  logic [QW-1:0]  inv_d, inv_q;

  always_comb begin
    rem_d[0] = CW'({cof_mag_i, {SHIFT{1'b0}}});
    quo_d[0] = '0;
    ovf_d    = (rem_d[0] >= (CW'(det_mag_i) << QW));
    for (int k = 0; k < QW; k++) begin
      sub[k] = {1'b0, rem_q[k]} - {1'b0, CW'(den_q[k]) << (QW - 1 - k)};
      rem_d[k+1] = sub[k][CW] ? rem_q[k] : sub[k][CW-1:0];
      quo_d[k+1] = {quo_q[k][QW-2:0], ~sub[k][CW]};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem_d[0];
    quo_q[0]  <= quo_d[0];
    den_q[0]  <= det_mag_i;
    ovf_q[0]  <= ovf_d;
    neg_q[0]  <= cof_neg_i ^ det_neg_i;
    zero_q[0] <= det_zero_i;
    for (int k = 0; k < QW; k++) begin
      rem_q[k+1]  <= rem_d[k+1];
      quo_q[k+1]  <= quo_d[k+1];
      den_q[k+1]  <= den_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      neg_q[k+1]  <= neg_q[k];
      zero_q[k+1] <= zero_q[k];
    end
    inv_q <= inv_d;
  end

  // saturate to the signed output range
  always_comb begin
    if (zero_q[QW]) begin
      inv_d = '0;
    end else if (neg_q[QW]) begin
      if (ovf_q[QW] || (quo_q[QW] > NEG_MIN)) begin
        inv_d = NEG_MIN;
      end else begin
        inv_d = -quo_q[QW];
      end
    end else begin
      if (ovf_q[QW] || (quo_q[QW] > POS_MAX)) begin
        inv_d = POS_MAX;
      end else begin
        inv_d = quo_q[QW];
      end
    end
  end

  assign inv_o = inv_q;

endmodule

[rtl/mi3_chk.sv]
// port-level checker for the 3x3 matrix inverse unit, with its bind
`include "matrix_inverse_3x3_unit_defines.svh"

module mi3_chk #(
  parameter int unsigned LAT = 38
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        singular_o,
  input logic [31:0] inv_r0c0_o,
  input logic [31:0] inv_r1c1_o,
  input logic [31:0] inv_r2c2_o
);

  `MI3_ASSERT_NEVER(a_never_busy, busy, "busy raised")

  `MI3_ASSERT_IMP(a_done_latency, done_o, $past(start && !busy, LAT),
    "result without a transaction at fixed latency")

  `MI3_ASSERT_IMP(a_singular_zero, done_o && singular_o,
    (inv_r0c0_o == '0) && (inv_r1c1_o == '0) && (inv_r2c2_o == '0),
    "singular result with nonzero entries")

endmodule

bind matrix_inverse_3x3_unit mi3_chk #(.LAT(38)) u_mi3_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .singular_o (singular_o),
  .inv_r0c0_o (inv_r0c0_o),
  .inv_r1c1_o (inv_r1c1_o),
  .inv_r2c2_o (inv_r2c2_o)
);

[tb/sv/matrix_inverse_3x3_unit_checker.sv]
// checker for the 3x3 matrix inverse unit: predicts each inverse and compares results
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   busy,
  input  logic [mi3_pkg::IW-1:0] m_i [mi3_pkg::NENT],
  input  logic                   done_o,
  input  logic [mi3_pkg::QW-1:0] inv_i [mi3_pkg::NENT],
  input  logic                   singular_o,
  output int                     err_count_o,
  output int                     pending_o
);
  import mi3_pkg::*;

  typedef struct {
    logic [QW-1:0] inv [NENT];
    logic          sing;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic logic [QW-1:0] scaled_quotient(longint cof, longint det);
    longint unsigned n, d, q, cap;
    logic neg;
    n   = (cof < 0) ? -cof : cof;
    d   = (det < 0) ? -det : det;
    neg = (cof < 0) != (det < 0);
    q   = (n << 28) / d;
    cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > cap) q = cap;
    if (neg) q = -q;
    return q[QW-1:0];
  endfunction

  function automatic inverse_t invert(logic [IW-1:0] m [NENT]);
    inverse_t r;
    longint x [NENT];
    longint adj [NENT];
    longint det;
    for (int k = 0; k < NENT; k++) x[k] = longint'($signed(m[k]));
    adj[0] = x[4] * x[8] - x[5] * x[7];
    adj[3] = x[5] * x[6] - x[3] * x[8];
    adj[6] = x[3] * x[7] - x[4] * x[6];
    adj[1] = x[2] * x[7] - x[1] * x[8];
    adj[4] = x[0] * x[8] - x[2] * x[6];
    adj[7] = x[1] * x[6] - x[0] * x[7];
    adj[2] = x[1] * x[5] - x[2] * x[4];
    adj[5] = x[2] * x[3] - x[0] * x[5];
    adj[8] = x[0] * x[4] - x[1] * x[3];
    det = adj[0] * x[0] + adj[3] * x[1] + adj[6] * x[2];
    r.sing = (det == 0);
    for (int k = 0; k < NENT; k++) r.inv[k] = r.sing ? '0 : scaled_quotient(adj[k], det);
    return r;
  endfunction

  assign pending_o = inverse_q.size();

  always @(posedge clk_i) begin
    inverse_t exp_r;
    int errs;
    errs = 0;
    if (rst_ni && start && !busy) inverse_q.push_back(invert(m_i));
    if (rst_ni && done_o) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected transaction, singular %0b", $time, singular_o);
        errs = errs + 1;
      end else begin
        exp_r = inverse_q.pop_front();
        if (singular_o !== exp_r.sing) begin
          $display("%0t: singular expected %0b actual %0b", $time, exp_r.sing, singular_o);
          errs = errs + 1;
        end
        for (int k = 0; k < NENT; k++) begin
          if (inv_i[k] !== exp_r.inv[k]) begin
            $display("%0t: inv[%0d] expected %h actual %h", $time, k, exp_r.inv[k],
                     inv_i[k]);
            errs = errs + 1;
          end
        end
      end
    end
    if (!rst_ni) begin
      err_count_o <= 0;
    end else begin
      err_count_o <= err_count_o + errs;
    end
  end
endmodule

[tb/sv/matrix_inverse_3x3_unit_test.sv]
// testbench top for the 3x3 matrix inverse unit: stimulus and verdict
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_test;
  import mi3_pkg::*;

  localparam int MAX_CYCLES = 200000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic          busy_seen = 1'b0;
  logic [IW-1:0] m [NENT];
  logic          done_o;
  logic [QW-1:0] inv [NENT];
  logic          singular_o;
  int            err_count;
  int            pending;
  int            cycles = 0;

  always #4 clk_i = ~clk_i;

  matrix_inverse_3x3_unit u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .m_r0c0_i(m[0]), .m_r0c1_i(m[1]), .m_r0c2_i(m[2]),
    .m_r1c0_i(m[3]), .m_r1c1_i(m[4]), .m_r1c2_i(m[5]),
    .m_r2c0_i(m[6]), .m_r2c1_i(m[7]), .m_r2c2_i(m[8]),
    .done_o,
    .inv_r0c0_o(inv[0]), .inv_r0c1_o(inv[1]), .inv_r0c2_o(inv[2]),
    .inv_r1c0_o(inv[3]), .inv_r1c1_o(inv[4]), .inv_r1c2_o(inv[5]),
    .inv_r2c0_o(inv[6]), .inv_r2c1_o(inv[7]), .inv_r2c2_o(inv[8]),
    .singular_o
  );

  matrix_inverse_3x3_unit_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .m_i(m), .done_o, .inv_i(inv), .singular_o,
    .err_count_o(err_count), .pending_o(pending)
  );

  always @(negedge clk_i) busy_seen <= busy;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("matrix_inverse_3x3_unit_test: errors");
      $finish;
    end
  end

  task automatic send_matrix(logic [IW-1:0] a [NENT]);
    int gap;
    start <= 1'b1;
    for (int k = 0; k < NENT; k++) m[k] <= a[k];
    do @(posedge clk_i); while (busy_seen);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_rows(int v0, int v1, int v2, int v3, int v4, int v5,
                           int v6, int v7, int v8);
    logic [IW-1:0] a [NENT];
    a = '{v0[IW-1:0], v1[IW-1:0], v2[IW-1:0], v3[IW-1:0], v4[IW-1:0],
          v5[IW-1:0], v6[IW-1:0], v7[IW-1:0], v8[IW-1:0]};
    send_matrix(a);
  endtask

  initial begin
    logic [IW-1:0] a [NENT];
    int sel;
    for (int k = 0; k < NENT; k++) m[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_rows(4096, 0, 0, 0, 4096, 0, 0, 0, 4096);
    send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_rows(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_rows(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_rows(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
    send_rows(32767, 0, 0, 0, 32767, 0, 0, 0, 32767);
    send_rows(1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_rows(-1, 0, 0, 0, 1, 0, 0, 0, -1);
    send_rows(1, 32767, 0, 0, 1, 0, 0, 0, 1);
    send_rows(1, -32767, 0, 0, 1, 0, 0, 0, 1);
    send_rows(1, -32768, -32768, 0, 1, -32768, 0, 0, 1);
    send_rows(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 1);
    send_rows(0, 4096, 0, 4096, 0, 0, 0, 0, 4096);
    send_rows(2, 1, 0, 1, 2, 1, 0, 1, 2);
    send_rows(1, 2, 3, 4, 5, 6, 7, 8, 9);
    send_rows(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
    send_rows(-32768, 32767, 1, 5, -7, 32767, 3, -32768, -1);

    repeat (650) begin
      sel = $urandom_range(0, 9);
      for (int k = 0; k < NENT; k++) begin
        if (sel < 4) a[k] = IW'($urandom());
        else if (sel < 7) a[k] = IW'($signed($urandom_range(0, 16)) - 8);
        else a[k] = IW'($signed($urandom_range(0, 8192)) - 4096);
      end
      if (sel >= 8) begin
        // near-singular: last row close to the first
        for (int k = 0; k < 3; k++) a[6 + k] = a[k] + IW'($signed($urandom_range(0, 2)) - 1);
      end
      send_matrix(a);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DET_LAT + DIV_LAT + 10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("matrix_inverse_3x3_unit_test: clean");
    end else begin
      $display("matrix_inverse_3x3_unit_test: errors");
    end
    $finish;
  end
endmodule
